### hdl/sfb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CRC-8 byte fold for the serial frame builder.
// No dependencies; every other file imports this package.
package sfb_pkg;

    localparam int ByteW   = 8;
    localparam int CfgIdxW = 4;
    localparam int SlotW   = 3;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgPayloadLen = 4'd0;
    localparam logic [CfgIdxW-1:0] CfgCheckMode  = 4'd1;
    localparam logic [CfgIdxW-1:0] CfgCrcPoly    = 4'd2;
    localparam logic [CfgIdxW-1:0] CfgCrcSeed    = 4'd3;

    // Reset values of the configuration registers
    localparam logic [ByteW-1:0] RstPayloadLen = 8'd12;
    localparam logic             RstCheckMode  = 1'b0;
    localparam logic [ByteW-1:0] RstCrcPoly    = 8'h07;
    localparam logic [ByteW-1:0] RstCrcSeed    = 8'h00;

    localparam logic ModeCrc = 1'b0;
    localparam logic ModeXor = 1'b1;

    // Framing bytes
    localparam logic [ByteW-1:0] HdrFirst  = 8'h55;
    localparam logic [ByteW-1:0] HdrSecond = 8'hAA;
    localparam logic [ByteW-1:0] TrlFirst  = 8'h0D;
    localparam logic [ByteW-1:0] TrlSecond = 8'h0A;

    // Positions of the bytes that one payload byte can cause, in line order
    localparam logic [SlotW-1:0] SlotHdr1  = 3'd0;
    localparam logic [SlotW-1:0] SlotHdr2  = 3'd1;
    localparam logic [SlotW-1:0] SlotLen   = 3'd2;
    localparam logic [SlotW-1:0] SlotData  = 3'd3;
    localparam logic [SlotW-1:0] SlotCheck = 3'd4;
    localparam logic [SlotW-1:0] SlotTrl1  = 3'd5;
    localparam logic [SlotW-1:0] SlotTrl2  = 3'd6;

    typedef struct packed {
        logic [ByteW-1:0] payload_len;
        logic             check_mode;
        logic [ByteW-1:0] crc_poly;
        logic [ByteW-1:0] crc_seed;
    } t_cfg;

    // Everything the line side needs to send for one payload byte
    typedef struct packed {
        logic             hdr;
        logic [ByteW-1:0] len;
        logic [ByteW-1:0] data;
        logic             tail;
        logic [ByteW-1:0] check;
    } t_piece;

    // MSB-first CRC-8 over one byte, no reflection
    function automatic logic [ByteW-1:0] crc8_fold(input logic [ByteW-1:0] acc,
                                                   input logic [ByteW-1:0] b,
                                                   input logic [ByteW-1:0] poly);
        logic [ByteW-1:0] v;
        v = acc ^ b;
        for (int k = 0; k < ByteW; k++) begin
            if (v[ByteW-1]) begin
                v = {v[ByteW-2:0], 1'b0} ^ poly;
            end else begin
                v = {v[ByteW-2:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

### hdl/sfb_if.sv
`timescale 1ns / 1ps
// Handshake channels of the serial frame builder: payload in, line out, config.
// Depends on sfb_pkg.
interface sfb_in_if import sfb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] payload_byte;

    modport source (output valid, output payload_byte, input ready);
    modport sink   (input valid, input payload_byte, output ready);
endinterface

interface sfb_out_if import sfb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] line_byte;
    logic             frame_end;

    modport source (output valid, output line_byte, output frame_end, input ready);
    modport sink   (input valid, input line_byte, input frame_end, output ready);
endinterface

interface sfb_cfg_if import sfb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] reg_index;
    logic [ByteW-1:0]   data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

### hdl/serial_frame_builder_crc8.sv
`timescale 1ns / 1ps
// Serial frame builder: payload bytes in, framed line bytes with CRC-8/XOR check out.
// Depends on sfb_pkg, sfb_if, sfb_framer and sfb_emitter.
//
// Usage:
//   i_in   takes one payload byte per item. o_out gives the line stream, one byte
//   per item: 0x55 0xAA len, payload bytes, check byte, 0x0D 0x0A (frame_end set
//   on the 0x0A). i_cfg writes payload_len (0), check_mode (1), crc_poly (2) and
//   crc_seed (3); other indexes are dropped. Write config only while idle.
// Timing:
//   A payload byte taken from i_in is held in the piece register while its line
//   bytes move to the output register, one byte per cycle unless the output is
//   stalled. The first byte of a frame also sends the header and length, the last
//   one the check byte and trailer; the next payload byte is taken in the cycle the
//   last line byte of the previous one goes to the output register.
// Reset: synchronous, active low; clears the frame count, the check value and
//   both valid flags, and loads the config defaults (length 12, CRC-8, 0x07, 0).
// Stall: while o_out.ready is low the output byte holds, one decoded payload byte
//   waits in the piece register, and i_in.ready drops once that register is full.
module serial_frame_builder_crc8 import sfb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfb_in_if.sink     i_in,
    sfb_out_if.source  o_out,
    sfb_cfg_if.sink    i_cfg
);

    t_cfg   r_cfg;
    logic   take;
    logic   piece_valid;
    t_piece piece;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.payload_len <= RstPayloadLen;
            r_cfg.check_mode  <= RstCheckMode;
            r_cfg.crc_poly    <= RstCrcPoly;
            r_cfg.crc_seed    <= RstCrcSeed;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                CfgPayloadLen: r_cfg.payload_len <= i_cfg.data;
                CfgCheckMode:  r_cfg.check_mode  <= i_cfg.data[0];
                CfgCrcPoly:    r_cfg.crc_poly    <= i_cfg.data;
                CfgCrcSeed:    r_cfg.crc_seed    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    sfb_framer u_framer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cfg         (r_cfg),
        .i_take        (take),
        .o_piece_valid (piece_valid),
        .o_piece       (piece)
    );

    sfb_emitter u_emitter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_piece_valid (piece_valid),
        .i_piece       (piece),
        .o_take        (take),
        .o_out         (o_out)
    );

endmodule

### hdl/sfb_framer.sv
`timescale 1ns / 1ps
// Frame state and check accumulation: turns one payload byte into a piece register.
// Depends on sfb_pkg and sfb_if.
module sfb_framer import sfb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfb_in_if.sink     i_in,
    input  t_cfg       i_cfg,
    input  logic       i_take,
    output logic       o_piece_valid,
    output t_piece     o_piece
);

    logic             r_pc_valid;
    t_piece           r_piece;
    logic [ByteW-1:0] r_cnt;
    logic [ByteW-1:0] r_acc;

    logic             accept;
    logic             first;
    logic [ByteW-1:0] acc_base;
    logic [ByteW-1:0] n_acc;
    logic [ByteW-1:0] cnt_inc;
    logic             tail;
    logic [ByteW-1:0] n_cnt;

    // Piece register frees up in the cycle its last byte moves to the line side
    assign i_in.ready = !r_pc_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        first    = (r_cnt == '0);
        acc_base = r_acc;
        if (first) begin
            acc_base = (i_cfg.check_mode == ModeCrc) ? i_cfg.crc_seed : '0;
        end
        if (i_cfg.check_mode == ModeXor) begin
            n_acc = acc_base ^ i_in.payload_byte;
        end else begin
            n_acc = crc8_fold(acc_base, i_in.payload_byte, i_cfg.crc_poly);
        end
        cnt_inc = r_cnt + 8'd1;
        tail    = (cnt_inc == i_cfg.payload_len);
        n_cnt   = tail ? '0 : cnt_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc_valid <= 1'b0;
            r_cnt      <= '0;
            r_acc      <= '0;
        end else begin
            if (accept) begin
                r_pc_valid <= 1'b1;
                r_cnt      <= n_cnt;
                r_acc      <= n_acc;
            end else if (i_take) begin
                r_pc_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_piece.hdr   <= first;
            r_piece.len   <= i_cfg.payload_len;
            r_piece.data  <= i_in.payload_byte;
            r_piece.tail  <= tail;
            r_piece.check <= n_acc;
        end
    end

    assign o_piece_valid = r_pc_valid;
    assign o_piece       = r_piece;

`ifndef SYNTHESIS
    a_take_needs_piece: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> r_pc_valid)
        else $error("piece taken while none held");
    a_tail_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && tail |=> r_cnt == '0)
        else $error("frame count not cleared after last payload byte");
    a_first_has_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (r_cnt == '0) |=> r_piece.hdr)
        else $error("first byte of frame lost its header");
`endif

endmodule

### hdl/sfb_emitter.sv
`timescale 1ns / 1ps
// Line side: walks the bytes of one piece into the output register, one per cycle
// unless the output is stalled. Depends on sfb_pkg and sfb_if.
module sfb_emitter import sfb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_piece_valid,
    input  t_piece     i_piece,
    output logic       o_take,
    sfb_out_if.source  o_out
);

    logic             r_active;
    logic [SlotW-1:0] r_slot;
    logic             r_out_valid;
    logic [ByteW-1:0] r_out_byte;
    logic             r_out_end;

    logic             load;
    logic [SlotW-1:0] cur;
    logic [SlotW-1:0] last;
    logic [ByteW-1:0] slot_byte;

    assign load = i_piece_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        if (r_active) begin
            cur = r_slot;
        end else begin
            cur = i_piece.hdr ? SlotHdr1 : SlotData;
        end
        last = i_piece.tail ? SlotTrl2 : SlotData;
        case (cur)
            SlotHdr1:  slot_byte = HdrFirst;
            SlotHdr2:  slot_byte = HdrSecond;
            SlotLen:   slot_byte = i_piece.len;
            SlotData:  slot_byte = i_piece.data;
            SlotCheck: slot_byte = i_piece.check;
            SlotTrl1:  slot_byte = TrlFirst;
            SlotTrl2:  slot_byte = TrlSecond;
            default:   slot_byte = TrlSecond;
        endcase
    end

    assign o_take = load && (cur == last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_slot      <= SlotHdr1;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                if (cur == last) begin
                    r_active <= 1'b0;
                end else begin
                    r_active <= 1'b1;
                    r_slot   <= cur + 3'd1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= slot_byte;
            r_out_end  <= (cur == SlotTrl2);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.line_byte = r_out_byte;
    assign o_out.frame_end = r_out_end;

`ifndef SYNTHESIS
    a_end_on_trailer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_end |-> r_out_byte == TrlSecond)
        else $error("frame end marked on a byte other than the trailer");
    a_active_has_piece: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> i_piece_valid)
        else $error("mid-piece with no piece held");
`endif

endmodule

### bench/tb_serial_frame_builder_crc8.sv
`timescale 1ns / 1ps
// Testbench for serial_frame_builder_crc8: payload bytes and register writes in,
// framed line stream predicted alongside and checked byte by byte in order.
// Depends on sfb_pkg, the sfb_if channel interfaces and the block's RTL.
module tb_serial_frame_builder_crc8;
    import sfb_pkg::*;

    localparam logic [CfgIdxW-1:0] CfgFirstUnused = 4'd4;
    localparam logic [CfgIdxW-1:0] CfgLastIndex   = {CfgIdxW{1'b1}};
    localparam int unsigned RandomItems = 175;
    localparam int unsigned DrainLimit  = 200000;
    localparam int unsigned TailCycles  = 20;

    typedef struct {
        logic [ByteW-1:0] line_byte;
        logic             frame_end;
    } t_line_word;

    logic i_clk;
    logic i_rst_n;

    sfb_in_if  in_ch ();
    sfb_out_if out_ch ();
    sfb_cfg_if cfg_ch ();

    serial_frame_builder_crc8 uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Line bytes still owed by the block, oldest first
    t_line_word  line_queue[$];
    int unsigned error_count;
    int unsigned payload_sent;

    // Predicted registers and frame progress
    logic [ByteW-1:0] frame_len;
    logic             frame_mode;
    logic [ByteW-1:0] frame_poly;
    logic [ByteW-1:0] frame_seed;
    logic [ByteW-1:0] frame_count;
    logic [ByteW-1:0] frame_check;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Bit-serial CRC-8, MSB first: shift each data bit against the register top
    function automatic logic [ByteW-1:0] crc8_shift(input logic [ByteW-1:0] acc,
                                                    input logic [ByteW-1:0] data,
                                                    input logic [ByteW-1:0] poly);
        logic [ByteW-1:0] r;
        logic             fb;
        r = acc;
        for (int i = ByteW - 1; i >= 0; i--) begin
            fb = r[ByteW-1] ^ data[i];
            r  = {r[ByteW-2:0], 1'b0} ^ (fb ? poly : '0);
        end
        return r;
    endfunction

    function automatic void owe_line(input logic [ByteW-1:0] b, input logic last);
        t_line_word w;
        w.line_byte = b;
        w.frame_end = last;
        line_queue.push_back(w);
    endfunction

    function automatic void predict_payload(input logic [ByteW-1:0] data);
        if (frame_count == '0) begin
            owe_line(HdrFirst, 1'b0);
            owe_line(HdrSecond, 1'b0);
            owe_line(frame_len, 1'b0);
            frame_check = (frame_mode == ModeCrc) ? frame_seed : '0;
        end
        owe_line(data, 1'b0);
        if (frame_mode == ModeCrc) begin
            frame_check = crc8_shift(frame_check, data, frame_poly);
        end else begin
            frame_check = frame_check ^ data;
        end
        frame_count = frame_count + 1'b1;
        if (frame_count == frame_len) begin
            owe_line(frame_check, 1'b0);
            owe_line(TrlFirst, 1'b0);
            owe_line(TrlSecond, 1'b1);
            frame_count = '0;
        end
    endfunction

    function automatic void apply_register(input logic [CfgIdxW-1:0] idx,
                                           input logic [ByteW-1:0] data);
        case (idx)
            CfgPayloadLen: frame_len  = data;
            CfgCheckMode:  frame_mode = data[0];
            CfgCrcPoly:    frame_poly = data;
            CfgCrcSeed:    frame_seed = data;
            default: ;
        endcase
    endfunction

    // Predict on every accepted item and check every accepted line byte
    always @(posedge i_clk) begin
        t_line_word want;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                apply_register(cfg_ch.reg_index, cfg_ch.data);
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_payload(in_ch.payload_byte);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (line_queue.size() == 0) begin
                    report_mismatch($sformatf("line byte %02h with nothing expected",
                                              out_ch.line_byte));
                end else begin
                    want = line_queue.pop_front();
                    if (out_ch.line_byte !== want.line_byte) begin
                        report_mismatch($sformatf("line_byte got %02h, want %02h",
                                                  out_ch.line_byte, want.line_byte));
                    end
                    if (out_ch.frame_end !== want.frame_end) begin
                        report_mismatch($sformatf("frame_end got %b, want %b on byte %02h",
                                                  out_ch.frame_end, want.frame_end,
                                                  want.line_byte));
                    end
                end
            end
        end
    end

    // Line-side stalls: runs of ready, mostly short drops and a few long ones
    initial begin
        int unsigned run_hi;
        int unsigned run_lo;
        int unsigned roll;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= 1'b1;
            roll   = $urandom_range(0, 99);
            run_hi = (roll < 10) ? $urandom_range(100, 300) : $urandom_range(1, 30);
            repeat (run_hi - 1) @(negedge i_clk);
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                run_lo = 0;
            end else if (roll < 92) begin
                run_lo = $urandom_range(1, 3);
            end else begin
                run_lo = $urandom_range(10, 40);
            end
            if (run_lo != 0) begin
                @(negedge i_clk);
                out_ch.ready <= 1'b0;
                repeat (run_lo - 1) @(negedge i_clk);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_payload(input logic [ByteW-1:0] data);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.payload_byte <= data;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        payload_sent++;
    endtask

    task automatic send_random_bytes(input int unsigned count);
        repeat (count) send_payload(8'($urandom));
    endtask

    // Drop valid and wait for every owed line byte
    task automatic settle();
        int unsigned waited;
        waited = 0;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (line_queue.size() != 0 && waited < DrainLimit) begin
            @(negedge i_clk);
            waited++;
        end
    endtask

    task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                  input logic [ByteW-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.data      <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Default registers, corner payload values
    task automatic test_default_config();
        logic [ByteW-1:0] corner_bytes [12];
        corner_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA,
                         8'h0D, 8'h0A, 8'h7F, 8'hFE, 8'h5A, 8'hC3};
        foreach (corner_bytes[i]) send_payload(corner_bytes[i]);
        settle();
    endtask

    task automatic test_one_byte_frames();
        write_register(CfgPayloadLen, 8'd1);
        write_register(CfgCheckMode, {7'd0, ModeCrc});
        write_register(CfgCrcPoly, 8'hFF);
        write_register(CfgCrcSeed, 8'hFF);
        send_payload(8'h00);
        send_payload(8'hFF);
        settle();
        write_register(CfgCheckMode, {7'd0, ModeXor});
        send_payload(8'hA5);
        settle();
    endtask

    // Writes to unused indexes must leave the registers alone
    task automatic test_unused_index();
        write_register(CfgFirstUnused, 8'hFF);
        write_register(CfgLastIndex, 8'h00);
        write_register(CfgPayloadLen, 8'd2);
        write_register(CfgCheckMode, {7'd0, ModeCrc});
        write_register(CfgCrcPoly, 8'h00);
        write_register(CfgCrcSeed, 8'h00);
        write_register(CfgFirstUnused, 8'h5A);
        send_random_bytes(2);
        settle();
    endtask

    // Mode, poly and seed switched inside a frame; length lowered but not passed
    task automatic test_mid_frame_changes();
        write_register(CfgPayloadLen, 8'd6);
        write_register(CfgCrcPoly, 8'h31);
        write_register(CfgCrcSeed, 8'h3C);
        send_random_bytes(2);
        settle();
        write_register(CfgCheckMode, {7'd0, ModeXor});
        write_register(CfgCrcSeed, 8'h99);
        write_register(CfgCrcPoly, 8'h1D);
        send_random_bytes(2);
        settle();
        write_register(CfgCheckMode, {7'd0, ModeCrc});
        send_random_bytes(2);
        settle();
        write_register(CfgPayloadLen, 8'd8);
        send_random_bytes(3);
        settle();
        write_register(CfgPayloadLen, 8'd4);
        send_payload(8'($urandom));
        settle();
    endtask

    // Length zero goes out as 0x00; raise it to two so the next byte closes the frame
    task automatic test_zero_length();
        write_register(CfgPayloadLen, 8'd0);
        write_register(CfgCheckMode, {7'd0, ModeXor});
        send_random_bytes(1);
        settle();
        write_register(CfgPayloadLen, 8'd2);
        send_random_bytes(1);
        settle();
    endtask

    // Length dropped to zero below the count: the frame closes once the count wraps
    task automatic test_length_passed();
        write_register(CfgPayloadLen, 8'd200);
        write_register(CfgCheckMode, {7'd0, ModeCrc});
        send_random_bytes(20);
        settle();
        write_register(CfgPayloadLen, 8'd0);
        send_random_bytes(236);
        settle();
    endtask

    task automatic test_random_traffic();
        int unsigned target;
        int unsigned new_len;
        target = payload_sent + RandomItems;
        while (payload_sent < target) begin
            if ($urandom_range(0, 2) == 0) begin
                // keep new length above the count so frames stay short
                if ($urandom_range(0, 1) == 0) begin
                    new_len = frame_count + $urandom_range(1, 8);
                    if (new_len > 255) new_len = 255;
                    write_register(CfgPayloadLen, 8'(new_len));
                end
                if ($urandom_range(0, 1) == 0) write_register(CfgCheckMode, 8'($urandom));
                if ($urandom_range(0, 1) == 0) write_register(CfgCrcPoly, 8'($urandom));
                if ($urandom_range(0, 1) == 0) write_register(CfgCrcSeed, 8'($urandom));
                if ($urandom_range(0, 6) == 0) begin
                    write_register(CfgIdxW'($urandom_range(CfgFirstUnused, CfgLastIndex)),
                                   8'($urandom));
                end
            end
            send_random_bytes($urandom_range(1, 24));
            settle();
        end
    endtask

    initial begin
        error_count  = 0;
        payload_sent = 0;
        frame_len    = RstPayloadLen;
        frame_mode   = RstCheckMode;
        frame_poly   = RstCrcPoly;
        frame_seed   = RstCrcSeed;
        frame_count  = '0;
        frame_check  = '0;

        in_ch.valid        = 1'b0;
        in_ch.payload_byte = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.reg_index   = '0;
        cfg_ch.data        = '0;
        i_rst_n            = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_config();
        test_one_byte_frames();
        test_unused_index();
        test_mid_frame_changes();
        test_zero_length();
        test_length_passed();
        test_random_traffic();

        settle();
        repeat (TailCycles) @(negedge i_clk);
        if (line_queue.size() != 0) begin
            report_mismatch($sformatf("%0d line bytes never arrived", line_queue.size()));
        end
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/sfb_pkg.sv
hdl/sfb_if.sv
hdl/sfb_framer.sv
hdl/sfb_emitter.sv
hdl/serial_frame_builder_crc8.sv
bench/tb_serial_frame_builder_crc8.sv
